// ----- rtl/hall_tach_pkg.sv -----
// Package: shared types and constants of the Hall-edge interval tachometer.
package hall_tach_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [1:0] REG_STALL_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_PULSES_PER_REV = 2'd2;

  // Register reset values
  localparam logic [19:0] MIN_INTERVAL_RST = 20'd100;
  localparam logic [31:0] STALL_TIMEOUT_RST = 32'd500000;
  localparam logic [6:0] PULSES_PER_REV_RST = 7'd2;

  // 60 s/min * 1e6 us/s * 16 sub-units, fits in 30 bits
  localparam logic [29:0] RPM_X16_NUM = 30'd960000000;
  localparam int unsigned QUO_W = 30;
  localparam int unsigned DEN_W = 39;   // 32-bit period times 7-bit pulse count

  typedef enum logic [2:0] {
    S_IDLE,
    S_DT,
    S_UPD,
    S_FRESH,
    S_MUL,
    S_DIV,
    S_DONE
  } tach_state_t;

endpackage

// ----- rtl/hall_edge_interval_tach.sv -----
// Top level: Hall-edge interval tachometer with smoothed period and rpm output.
// Sequence: each item passes S_DT, S_UPD, S_FRESH and S_MUL, then the 30-step restoring
//   divider (S_DIV) only when rpm is nonzero (fresh and a nonzero period), then S_DONE.
// One item at a time: in_tready is high only while idle, after S_DONE has let the last go.
// A finished result waits in the output register; the next item may already start.
// Reset (rst_n low, synchronous): config back to defaults, smoothed period, last edge
//   time, edge flag and edge count cleared, sequencer idle, output channel empty.
module hall_edge_interval_tach (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] now_us
  input  logic        in_tuser,    // [0] func (1 = sensor edge)
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // [31:0] period_us, [61:32] rpm_x16,
                                   // [93:62] edge_count, [95:94] zero
  output logic [1:0]  out_tuser,   // [0] fresh, [1] edge_taken
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned QW = hall_tach_pkg::QUO_W;
  localparam int unsigned DW = hall_tach_pkg::DEN_W;

  hall_tach_pkg::tach_state_t state_r, state_nxt;

  // config registers
  logic [19:0] min_int_r;
  logic [31:0] stall_r;
  logic [6:0]  ppr_r;

  // persistent tach state
  logic [31:0] period_r, period_nxt;
  logic [31:0] last_r, last_nxt;
  logic        have_r, have_nxt;
  logic [31:0] count_r, count_nxt;

  // per-item working registers
  logic [31:0] now_r;
  logic        func_r;
  logic [31:0] dt_r, dt_nxt;
  logic        taken_r, taken_nxt;
  logic        fresh_r, fresh_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [QW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [4:0]    cnt_r, cnt_nxt;

  // output register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [95:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  logic in_xfer;
  logic out_free;
  logic rpm_needed;

  logic [32:0]   diff;
  logic [32:0]   step;
  logic [6:0]    ppr_eff;
  logic [QW:0]   rem_sh;
  logic          q_bit;

  assign in_tready  = (state_r == hall_tach_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign rpm_needed = fresh_r && (period_r != 32'd0);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hall_tach_pkg::S_IDLE:  if (in_xfer) state_nxt = hall_tach_pkg::S_DT;
      hall_tach_pkg::S_DT:    state_nxt = hall_tach_pkg::S_UPD;
      hall_tach_pkg::S_UPD:   state_nxt = hall_tach_pkg::S_FRESH;
      hall_tach_pkg::S_FRESH: state_nxt = hall_tach_pkg::S_MUL;
      hall_tach_pkg::S_MUL: begin
        state_nxt = rpm_needed ? hall_tach_pkg::S_DIV : hall_tach_pkg::S_DONE;
      end
      hall_tach_pkg::S_DIV:   if (cnt_r == 5'd0) state_nxt = hall_tach_pkg::S_DONE;
      hall_tach_pkg::S_DONE:  if (out_free) state_nxt = hall_tach_pkg::S_IDLE;
      default:                state_nxt = hall_tach_pkg::S_IDLE;
    endcase
  end

  // EMA step: floor((dt - avg) / 4) as an arithmetic shift of the exact difference
  assign diff    = {1'b0, dt_r} - {1'b0, period_r};
  assign step    = $signed(diff) >>> 2;
  assign ppr_eff = (ppr_r == 7'd0) ? 7'd1 : ppr_r;

  // restoring divider: bring down one dividend bit per cycle, MSB first
  assign rem_sh = {rem_r, hall_tach_pkg::RPM_X16_NUM[cnt_r]};
  assign q_bit  = {{(DW-QW-1){1'b0}}, rem_sh} >= den_r;

  // ---------------- datapath / outputs ----------------
  always_comb begin
    period_nxt     = period_r;
    last_nxt       = last_r;
    have_nxt       = have_r;
    count_nxt      = count_r;
    dt_nxt         = dt_r;
    taken_nxt      = taken_r;
    fresh_nxt      = fresh_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    case (state_r)
      hall_tach_pkg::S_DT: begin
        dt_nxt    = now_r - last_r;
        taken_nxt = 1'b0;
      end
      hall_tach_pkg::S_UPD: begin
        if (func_r) begin
          if (!have_r || (dt_r >= {12'd0, min_int_r})) begin
            if (have_r) begin
              if ((period_r == 32'd0) || (dt_r > stall_r)) begin
                period_nxt = dt_r;         // seed: first interval or after a stall
              end else begin
                period_nxt = period_r + step[31:0];
              end
            end
            last_nxt  = now_r;
            have_nxt  = 1'b1;
            count_nxt = count_r + 32'd1;
            taken_nxt = 1'b1;
          end
        end
      end
      hall_tach_pkg::S_FRESH: begin
        fresh_nxt = have_r && ((now_r - last_r) <= stall_r);
      end
      hall_tach_pkg::S_MUL: begin
        den_nxt = DW'(period_r * ppr_eff);
        rem_nxt = '0;
        quo_nxt = '0;
        cnt_nxt = 5'(QW - 1);
      end
      hall_tach_pkg::S_DIV: begin
        if (q_bit) begin
          rem_nxt = QW'(rem_sh - den_r[QW:0]);
        end else begin
          rem_nxt = rem_sh[QW-1:0];
        end
        quo_nxt = {quo_r[QW-2:0], q_bit};
        cnt_nxt = cnt_r - 5'd1;
      end
      hall_tach_pkg::S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, count_r, (rpm_needed ? quo_r : {QW{1'b0}}), period_r};
          out_tuser_nxt  = {taken_r, fresh_r};
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= hall_tach_pkg::S_IDLE;
      min_int_r    <= hall_tach_pkg::MIN_INTERVAL_RST;
      stall_r      <= hall_tach_pkg::STALL_TIMEOUT_RST;
      ppr_r        <= hall_tach_pkg::PULSES_PER_REV_RST;
      period_r     <= '0;
      last_r       <= '0;
      have_r       <= 1'b0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      period_r     <= period_nxt;
      last_r       <= last_nxt;
      have_r       <= have_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          hall_tach_pkg::REG_MIN_INTERVAL:   min_int_r <= cfg_wdata[19:0];
          hall_tach_pkg::REG_STALL_TIMEOUT:  stall_r   <= cfg_wdata;
          hall_tach_pkg::REG_PULSES_PER_REV: ppr_r     <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r  <= in_tdata;
      func_r <= in_tuser;
    end
    dt_r        <= dt_nxt;
    taken_r     <= taken_nxt;
    fresh_r     <= fresh_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // ---------------- assertions ----------------
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted while an item is in work");

  a_stale_no_rpm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tuser_r[0]) |-> (out_tdata_r[61:32] == 30'd0))
    else $error("nonzero rpm on a stale result");

  a_no_period_no_rpm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tdata_r[31:0] == 32'd0)) |-> (out_tdata_r[61:32] == 30'd0))
    else $error("nonzero rpm without a period");

  a_taken_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[1]) |-> out_tuser_r[0])
    else $error("accepted edge reported stale");

endmodule

// ----- dv/hall_edge_interval_tach_tb.sv -----
// Testbench for the Hall-edge interval tachometer: scoreboard class and stream drivers.
`timescale 1ns / 100ps

module hall_edge_interval_tach_tb;

  // One expected output transfer, field by field
  typedef struct packed {
    logic [31:0] period_us;
    logic [29:0] rpm_x16;
    logic        fresh;
    logic [31:0] edge_count;
    logic        edge_taken;
  } tach_reading_t;

  // Keeps its own copy of the tach state and registers, predicts one reading per
  // accepted input transfer and checks output transfers in order.
  class tach_scoreboard;
    logic [19:0] min_gap     = hall_tach_pkg::MIN_INTERVAL_RST;
    logic [31:0] stall_limit = hall_tach_pkg::STALL_TIMEOUT_RST;
    logic [6:0]  ppr         = hall_tach_pkg::PULSES_PER_REV_RST;

    logic [31:0] period_avg = '0;
    logic [31:0] last_edge  = '0;
    logic        have_edge  = 1'b0;
    logic [31:0] edge_total = '0;

    tach_reading_t expected_readings[$];
    int unsigned errors, checked;
    int unsigned n_taken, n_dropped, n_seeded, n_stale, n_rpm;

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        hall_tach_pkg::REG_MIN_INTERVAL:   min_gap = val[19:0];
        hall_tach_pkg::REG_STALL_TIMEOUT:  stall_limit = val;
        hall_tach_pkg::REG_PULSES_PER_REV: ppr = val[6:0];
        default: ;
      endcase
    endfunction

    function void predict_reading(bit func, logic [31:0] stamp);
      tach_reading_t want;
      logic [31:0] dt, age;
      logic signed [63:0] diff, nudge;
      logic [63:0] den, quo;
      logic [6:0] ppr_eff;
      bit take;
      take = 1'b0;
      if (func) begin
        take = 1'b1;
        if (have_edge) begin
          dt = stamp - last_edge;
          if (dt < {12'd0, min_gap}) begin
            take = 1'b0;             // bounce
            n_dropped++;
          end else if (period_avg == 0 || dt > stall_limit) begin
            period_avg = dt;         // first interval or restart after stall
            n_seeded++;
          end else begin
            // floor((dt - avg) / 4) on the exact signed difference
            diff = $signed({32'd0, dt}) - $signed({32'd0, period_avg});
            nudge = diff >>> 2;
            period_avg = period_avg + nudge[31:0];
          end
        end
        if (take) begin
          last_edge = stamp;
          have_edge = 1'b1;
          edge_total = edge_total + 1;
          n_taken++;
        end
      end
      age = stamp - last_edge;
      want.period_us  = period_avg;
      want.fresh      = have_edge && (age <= stall_limit);
      want.edge_count = edge_total;
      want.edge_taken = take;
      want.rpm_x16    = '0;
      if (!want.fresh) n_stale++;
      if (want.fresh && period_avg != 0) begin
        ppr_eff = (ppr == 0) ? 7'd1 : ppr;
        den = {32'd0, period_avg} * {57'd0, ppr_eff};
        quo = {34'd0, hall_tach_pkg::RPM_X16_NUM} / den;
        want.rpm_x16 = quo[29:0];
        if (quo != 0) n_rpm++;
      end
      expected_readings.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reading(logic [95:0] data, logic [1:0] flags);
      tach_reading_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual data %h flags %b",
                 $time, data, flags);
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      compare_field("period_us", want.period_us, data[31:0]);
      compare_field("rpm_x16", {2'd0, want.rpm_x16}, {2'd0, data[61:32]});
      compare_field("edge_count", want.edge_count, data[93:62]);
      compare_field("fresh", {31'd0, want.fresh}, {31'd0, flags[0]});
      compare_field("edge_taken", {31'd0, want.edge_taken}, {31'd0, flags[1]});
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 40;   // longer than the divide path
  localparam int unsigned PHASE_ITEMS = 225;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;          // [31:0] now_us
  logic        in_tuser = 1'b0;        // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;              // [31:0] period_us, [61:32] rpm_x16, [93:62] edge_count
  logic [1:0]  out_tuser;              // [0] fresh, [1] edge_taken
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  tach_scoreboard sb = new();

  // Stimulus control, shared between the main flow and the output sink
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  bit          calm = 1'b0;           // last phase: no idling on either side
  int unsigned sink_hold = 0;
  int unsigned items_sent = 0;
  logic [31:0] stamp_now = '0;         // running timestamp for the random part

  always #5 clk = ~clk;

  hall_edge_interval_tach dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Output sink: check every transfer, then pick tready for the next edge.
  // Stalls come in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_reading(out_tdata, out_tuser);
    if (sink_hold == 0 && sink_idle_en && $urandom_range(0, 5) == 0)
      sink_hold = $urandom_range(1, 11);
    if (sink_hold != 0) begin
      out_tready <= 1'b0;
      sink_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One input transfer, with an optional idle burst ahead of it. tvalid is left
  // high afterwards so back-to-back items never toggle it within one step.
  task automatic send_item(input bit func, input logic [31:0] stamp);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= stamp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.predict_reading(func, stamp);
    items_sent++;
  endtask

  // Hold the sender until every predicted reading has been checked
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; block must be idle
  task automatic apply_config(input logic [19:0] gap_min, input logic [31:0] stall,
                              input logic [6:0] ppr);
    cfg_we    <= 1'b1;
    cfg_addr  <= hall_tach_pkg::REG_MIN_INTERVAL;
    cfg_wdata <= {12'd0, gap_min};
    @(posedge clk);
    sb.write_reg(hall_tach_pkg::REG_MIN_INTERVAL, {12'd0, gap_min});
    cfg_addr  <= hall_tach_pkg::REG_STALL_TIMEOUT;
    cfg_wdata <= stall;
    @(posedge clk);
    sb.write_reg(hall_tach_pkg::REG_STALL_TIMEOUT, stall);
    cfg_addr  <= hall_tach_pkg::REG_PULSES_PER_REV;
    cfg_wdata <= {25'd0, ppr};
    @(posedge clk);
    sb.write_reg(hall_tach_pkg::REG_PULSES_PER_REV, {25'd0, ppr});
    cfg_we <= 1'b0;
  endtask

  // Random traffic: mostly a steady edge train around a spin interval, mixed
  // with bounces, time samples, stall-boundary probes, debounce-boundary
  // edges and fully random timestamps.
  task automatic run_random(input int n);
    int unsigned spin, step;
    int kind;
    logic [31:0] stamp;
    bit func;
    spin = 1000;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        src_idle_en  = !calm && ($urandom_range(0, 3) != 0);
        sink_idle_en = !calm && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 3))
          0:       spin = sb.min_gap + $urandom_range(1, 3000);
          1:       spin = $urandom_range(1, 60000);
          2:       spin = sb.min_gap + $urandom_range(0, 1000000);
          default: spin = $urandom_range(1, 16);
        endcase
      end
      if (i == n / 2) drain();   // sender waits for an empty pipeline mid-phase
      kind = $urandom_range(0, 99);
      func = 1'b1;
      if (kind < 60) begin
        step  = spin - spin / 16 + $urandom_range(0, spin / 8);
        stamp = stamp_now + step;
      end else if (kind < 70) begin
        stamp = sb.last_edge + $urandom_range(0, sb.min_gap);
      end else if (kind < 85) begin
        func  = 1'b0;
        stamp = stamp_now + $urandom_range(0, spin);
      end else if (kind < 90) begin
        // just inside, on, or just past the stall timeout
        func  = 1'($urandom_range(0, 1));
        stamp = sb.last_edge + sb.stall_limit + $urandom_range(0, 2) - 1;
      end else if (kind < 95) begin
        func  = 1'($urandom_range(0, 1));
        stamp = $urandom();
      end else begin
        // on the debounce minimum or one below it
        stamp = sb.last_edge + sb.min_gap - $urandom_range(0, 1);
      end
      send_item(func, stamp);
      stamp_now = stamp;
    end
  endtask

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: min 100 us, stall 500000 us, 2 pulses per rev
    send_item(1'b0, 32'd0);              // sample before any edge: not fresh
    send_item(1'b1, 32'd1000);           // first edge: count only, no period
    send_item(1'b1, 32'd1050);           // bounce
    send_item(1'b1, 32'd1099);           // one below the debounce minimum
    send_item(1'b1, 32'd1100);           // exactly the minimum: seeds the period
    send_item(1'b1, 32'd11100);          // smoothing upward
    send_item(1'b1, 32'd13100);          // smoothing downward, negative step rounds down
    send_item(1'b0, 32'd513100);         // age equals the timeout: still fresh
    send_item(1'b0, 32'd513101);         // one past: stale, rpm zero
    send_item(1'b1, 32'd1013101);        // gap past the timeout: reseed
    send_item(1'b1, 32'hFFFF_F000);
    send_item(1'b1, 32'h0000_0C00);      // interval across timestamp wrap
    send_item(1'b0, 32'hFFFF_FFFF);
    send_item(1'b1, 32'hFFFF_FFFF);
    stamp_now = sb.last_edge;
    run_random(PHASE_ITEMS);
    drain();

    // No debounce, zero stall timeout, zero pulses per rev (taken as one)
    apply_config(20'd0, 32'd0, 7'd0);
    send_item(1'b1, 32'd100);            // reseed
    send_item(1'b1, 32'd103);            // reseed to a period of 3
    send_item(1'b1, 32'd103);            // zero intervals smooth it down ...
    send_item(1'b1, 32'd103);
    send_item(1'b1, 32'd103);            // ... to zero: no measurement again
    send_item(1'b0, 32'd103);            // fresh only at the edge time itself
    send_item(1'b1, 32'd108);            // period zero: seed again
    send_item(1'b1, 32'd109);            // period 1, one pulse: largest rpm
    send_item(1'b0, 32'd110);            // one past the edge: stale
    stamp_now = sb.last_edge;
    run_random(PHASE_ITEMS);
    drain();

    // Widest debounce, never stale, largest pulse count
    apply_config(20'hFFFFF, 32'hFFFF_FFFF, 7'h7F);
    run_random(PHASE_ITEMS);
    drain();

    // Long debounce, one-microsecond stall timeout, 64 pulses per rev
    apply_config(20'd1000000, 32'd1, 7'd64);
    run_random(PHASE_ITEMS);
    drain();

    // Back to the reset values, starting just below the timestamp wrap
    apply_config(hall_tach_pkg::MIN_INTERVAL_RST, hall_tach_pkg::STALL_TIMEOUT_RST,
                 hall_tach_pkg::PULSES_PER_REV_RST);
    stamp_now = 32'hFFF0_0000;
    run_random(PHASE_ITEMS);
    drain();

    // Random setting, no idling from here on
    apply_config(20'($urandom_range(0, 5000)), $urandom_range(1000, 2000000),
                 7'($urandom_range(1, 127)));
    calm = 1'b1;
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    run_random(PHASE_ITEMS);
    drain();

    $display("Run: %0d transfers in, %0d readings checked, 6 register settings",
             items_sent, sb.checked);
    $display("Edges taken %0d, bounces dropped %0d, period seeds %0d, stale %0d, rpm>0 %0d",
             sb.n_taken, sb.n_dropped, sb.n_seeded, sb.n_stale, sb.n_rpm);
    if (sb.errors == 0 && sb.expected_readings.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
